[rtl/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// uvs_pkg
// Shared widths, register indexes and types of the UV sphere index sequencer.
// ----------------------------------------------------------------------------
package uvs_pkg;

  // Largest slice or stack count in use; written values saturate to it
  localparam int MAX_DIVISIONS = 256;

  localparam int DIV_W     = 9;   // width of the slices and stacks registers
  localparam int CNT_W     = 8;   // band and slice counters
  localparam int VTX_W     = 16;  // vertex index
  localparam int CFG_IDX_W = 2;   // register index on the write port

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SLICES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STACKS = 2'd1;

  // Saturated counts and restart request from the register block
  typedef struct packed {
    logic [DIV_W-1:0] slices;
    logic [DIV_W-1:0] stacks;
    logic             restart;
  } uvs_ctrl_t;

  // One triangle of the index list
  typedef struct packed {
    logic [VTX_W-1:0] corner_first;
    logic [VTX_W-1:0] corner_second;
    logic [VTX_W-1:0] corner_third;
    logic             final_triangle;
  } uvs_tri_t;

  // Clamp a division count to [2, MAX_DIVISIONS]
  function automatic logic [DIV_W-1:0] sat_div(input logic [DIV_W-1:0] v);
    logic [DIV_W-1:0] r;
    r = v;
    if (v < DIV_W'(2)) begin
      r = DIV_W'(2);
    end else if (v > DIV_W'(MAX_DIVISIONS)) begin
      r = DIV_W'(MAX_DIVISIONS);
    end
    return r;
  endfunction

endpackage

[rtl/uvs_cfg.sv]
// ----------------------------------------------------------------------------
// uvs_cfg
// Slice and stack registers with saturation; a write to either register restarts the sequence.
// ----------------------------------------------------------------------------
module uvs_cfg
  import uvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0]     cfg_data,
  output uvs_ctrl_t            ctrl
);

  logic [DIV_W-1:0] slices;
  logic [DIV_W-1:0] stacks;

  // Hold the written values; an unknown index changes nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      slices <= DIV_W'(2);
      stacks <= DIV_W'(2);
    end else if (cfg_we) begin
      if (cfg_index == REG_SLICES) begin
        slices <= cfg_data;
      end
      if (cfg_index == REG_STACKS) begin
        stacks <= cfg_data;
      end
    end
  end

  // Drive clamped counts and the restart request
  always_comb begin
    ctrl.slices  = sat_div(slices);
    ctrl.stacks  = sat_div(stacks);
    ctrl.restart = cfg_we && (cfg_index == REG_SLICES || cfg_index == REG_STACKS);
  end

endmodule

[rtl/uvs_walker.sv]
// ----------------------------------------------------------------------------
// uvs_walker
// Mesh walk state (phase, band, slice, half-quad, row base) and the
// corner computation of the current triangle.
// ----------------------------------------------------------------------------
module uvs_walker
  import uvs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  uvs_ctrl_t ctrl,
  input  logic      accept,
  input  logic      restart,
  output uvs_tri_t  tri_out
);

  typedef enum logic [1:0] {
    PH_TOP    = 2'd0,
    PH_BAND   = 2'd1,
    PH_BOTTOM = 2'd2
  } phase_t;

  phase_t             phase, phase_next, e_phase;
  logic [CNT_W-1:0]   band_counter, band_counter_next, e_band;
  logic [CNT_W-1:0]   slice_counter, slice_counter_next, e_slice;
  logic               second_half, second_half_next, e_half;
  logic [VTX_W-1:0]   band_base, band_base_next, e_base;

  logic [CNT_W:0]     slice_inc;
  logic               last_slice;
  logic [CNT_W-1:0]   n;
  logic [VTX_W-1:0]   a, b, ai, an, bi, bn;

  always_comb begin
    // Apply restart request, and recover from the unused phase code
    e_phase = phase;
    e_band  = band_counter;
    e_slice = slice_counter;
    e_half  = second_half;
    e_base  = band_base;
    if (restart || !(phase == PH_TOP || phase == PH_BAND || phase == PH_BOTTOM)) begin
      e_phase = PH_TOP;
      e_band  = '0;
      e_slice = '0;
      e_half  = 1'b0;
      e_base  = VTX_W'(1);
    end

    // Neighbor slice with wrap at the last one
    slice_inc  = {1'b0, e_slice} + (CNT_W+1)'(1);
    last_slice = slice_inc >= ctrl.slices;
    n          = last_slice ? '0 : slice_inc[CNT_W-1:0];

    a  = e_base;
    b  = a + VTX_W'(ctrl.slices);
    ai = a + VTX_W'(e_slice);
    an = a + VTX_W'(n);
    bi = b + VTX_W'(e_slice);
    bn = b + VTX_W'(n);

    phase_next         = e_phase;
    band_counter_next  = e_band;
    slice_counter_next = e_slice;
    second_half_next   = e_half;
    band_base_next     = e_base;
    tri_out.final_triangle = 1'b0;

    unique case (e_phase)
      PH_BAND: begin
        if (!e_half) begin
          tri_out.corner_first  = ai;
          tri_out.corner_second = an;
          tri_out.corner_third  = bi;
          second_half_next      = 1'b1;
        end else begin
          tri_out.corner_first  = an;
          tri_out.corner_second = bn;
          tri_out.corner_third  = bi;
          second_half_next      = 1'b0;
          if (last_slice) begin
            slice_counter_next = '0;
            band_base_next     = b;
            if (({2'b00, e_band} + (CNT_W+2)'(3)) >= {1'b0, ctrl.stacks}) begin
              phase_next = PH_BOTTOM;
            end else begin
              band_counter_next = e_band + CNT_W'(1);
            end
          end else begin
            slice_counter_next = n;
          end
        end
      end
      PH_BOTTOM: begin
        tri_out.corner_first  = ai;
        tri_out.corner_second = an;
        tri_out.corner_third  = b;
        if (last_slice) begin
          // Close the mesh and rewind
          tri_out.final_triangle = 1'b1;
          phase_next         = PH_TOP;
          band_counter_next  = '0;
          slice_counter_next = '0;
          second_half_next   = 1'b0;
          band_base_next     = VTX_W'(1);
        end else begin
          slice_counter_next = n;
        end
      end
      default: begin
        // Top cap fan around the pole
        tri_out.corner_first  = '0;
        tri_out.corner_second = an;
        tri_out.corner_third  = ai;
        if (last_slice) begin
          slice_counter_next = '0;
          if (ctrl.stacks > DIV_W'(2)) begin
            phase_next        = PH_BAND;
            band_counter_next = '0;
          end else begin
            phase_next = PH_BOTTOM;
          end
        end else begin
          slice_counter_next = n;
        end
      end
    endcase
  end

  // Advance on each accepted request; a register write rewinds
  always_ff @(posedge clk) begin
    if (rst || ctrl.restart) begin
      phase         <= PH_TOP;
      band_counter  <= '0;
      slice_counter <= '0;
      second_half   <= 1'b0;
      band_base     <= VTX_W'(1);
    end else if (accept) begin
      phase         <= phase_next;
      band_counter  <= band_counter_next;
      slice_counter <= slice_counter_next;
      second_half   <= second_half_next;
      band_base     <= band_base_next;
    end
  end

endmodule

[rtl/uv_sphere_index_sequencer_core.sv]
// ----------------------------------------------------------------------------
// uv_sphere_index_sequencer_core
// Triangle index list of a latitude-longitude sphere, one triangle per request.
// ----------------------------------------------------------------------------
// Each accepted request yields one triangle: top cap fan, then two triangles
// per quad of every interior band, then the bottom cap fan, with the final
// triangle flagged and the next request starting over. A request with restart
// set emits the first triangle. The block takes one request every cycle and
// shows its triangle in the next cycle in an output register; a request is
// stalled only while that register holds a triangle that is itself stalled.
// Slice and stack counts clamp to [2, 256]; a register write rewinds the walk.
module uv_sphere_index_sequencer_core
  import uvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIV_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 restart,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VTX_W-1:0]     corner_first,
  output logic [VTX_W-1:0]     corner_second,
  output logic [VTX_W-1:0]     corner_third,
  output logic                 final_triangle
);

  uvs_ctrl_t ctrl;
  uvs_tri_t  tri_now;
  logic      accept;

  uvs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl)
  );

  uvs_walker u_walker (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .accept  (accept),
    .restart (restart),
    .tri_out (tri_now)
  );

  // Stall only while the held triangle is not taken
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || (out_valid && out_stall);
    end
  end

  // Load the triangle of each accepted request
  always_ff @(posedge clk) begin
    if (accept) begin
      corner_first   <= tri_now.corner_first;
      corner_second  <= tri_now.corner_second;
      corner_third   <= tri_now.corner_third;
      final_triangle <= tri_now.final_triangle;
    end
  end

endmodule

[rtl/uvs_checker.sv]
// ----------------------------------------------------------------------------
// uvs_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module uvs_checker
  import uvs_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 restart,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic [VTX_W-1:0]     corner_first,
  input logic [VTX_W-1:0]     corner_second,
  input logic [VTX_W-1:0]     corner_third,
  input logic                 final_triangle
);

  // Every accepted request shows a triangle next cycle
  a_req_gives_tri: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted request produced no triangle");

  // A restart request gives the first top-cap triangle
  a_restart_first: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && restart) |=>
      (corner_first == '0 && corner_third == VTX_W'(1) && !final_triangle))
    else $error("restart did not emit the first triangle");

  // Requests are held off only while a triangle waits
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("request stalled with no waiting triangle");

  // A stalled triangle holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(corner_first) && $stable(corner_second)
       && $stable(corner_third) && $stable(final_triangle)))
    else $error("stalled triangle changed");

endmodule

bind uv_sphere_index_sequencer_core uvs_checker u_uvs_checker (.*);
